>>> rtl/cppu_pkg.sv
// Shared types and constants of the camera packet pixel unpacker.
`default_nettype none
package cppu_pkg;

    localparam int PB_W          = 13;   // packet_bytes register width
    localparam int MIN_PACKET    = 12;
    localparam int HEADER_BYTES  = 4;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    // Pixel formats
    localparam logic [2:0] FMT_YUV444 = 3'd0;
    localparam logic [2:0] FMT_YUV422 = 3'd1;
    localparam logic [2:0] FMT_YUV411 = 3'd2;
    localparam logic [2:0] FMT_RGB888 = 3'd3;
    localparam logic [2:0] FMT_Y8     = 3'd4;
    localparam logic [2:0] FMT_Y16    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_STRIP_HEADER = 2'd1;
    localparam logic [1:0] CFG_PACKET_BYTES = 2'd2;

    typedef struct packed {
        logic [2:0]      pixel_format;
        logic            strip_header;
        logic [PB_W-1:0] packet_bytes;
    } cfg_t;

    // Work queued from the front to the back
    typedef enum logic [2:0] {
        CMD_STORE_U   = 3'd0,  // keep u (or r)
        CMD_STORE_A   = 3'd1,  // keep first luma (or g)
        CMD_STORE_B   = 3'd2,  // keep second luma
        CMD_EMIT_V    = 3'd3,  // keep v, pixel from luma a
        CMD_EMIT_V2   = 3'd4,  // keep v, pixels from luma a then luma b
        CMD_EMIT_Y    = 3'd5,  // pixel from this luma and held chroma
        CMD_EMIT_RGB  = 3'd6,  // pixel from held r, g and this b
        CMD_EMIT_GRAY = 3'd7   // gray pixel from this byte
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } entry_t;

    // One pixel request to the color pipeline; RGB rides in c0..c2 as r,g,b
    typedef struct packed {
        logic       is_yuv;
        logic [7:0] c0;   // y or r
        logic [7:0] c1;   // u or g
        logic [7:0] c2;   // v or b
        logic       last;
    } px_req_t;

endpackage
`default_nettype wire

>>> rtl/cppu_front.sv
// Front end: packet position tracking and byte classification.
`default_nettype none
module cppu_front #(
    parameter int PACKET_BYTES_MAX = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             packet_start,
    input  wire cppu_pkg::cfg_t   cfg,
    input  wire logic             fifo_full,
    output logic                  push,
    output cppu_pkg::entry_t      entry
);
    import cppu_pkg::*;

    localparam int POS_W  = $clog2(PACKET_BYTES_MAX);
    localparam int SIZE_W = $clog2(PACKET_BYTES_MAX + 1);
    localparam int CW     = (SIZE_W > PB_W) ? SIZE_W : PB_W;
    localparam logic [CW-1:0] MAX_C = CW'(PACKET_BYTES_MAX);
    localparam logic [CW-1:0] MIN_C = CW'(MIN_PACKET);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]        mod3_reg, mod3_next;   // pos_reg mod 3

    logic              accept;
    logic [CW-1:0]     size_c;
    logic [SIZE_W-1:0] size, head, payload, pos_ext, pos_inc, p;
    logic [1:0]        m3, p3;
    logic              wrap, in_pay, fmt_ok, full_grp, need;
    logic [2:0]        gs, ph, ph6;
    logic [SIZE_W:0]   grp_end;
    cmd_t              cmd;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    // Effective packet size, clamped
    always_comb
    begin
        size_c = CW'(cfg.packet_bytes);
        if (size_c < MIN_C)
            size_c = MIN_C;
        else if (size_c > MAX_C)
            size_c = MAX_C;
    end

    assign size    = SIZE_W'(size_c);
    assign head    = cfg.strip_header ? SIZE_W'(HEADER_BYTES) : '0;
    assign payload = size - (head << 1);

    assign pos_ext = packet_start ? '0 : SIZE_W'(pos_reg);
    assign m3      = packet_start ? 2'd0 : mod3_reg;
    assign pos_inc = pos_ext + SIZE_W'(1);
    assign wrap    = (pos_inc >= size);

    assign pos_next  = wrap ? '0 : POS_W'(pos_inc);
    assign mod3_next = wrap ? 2'd0 : ((m3 == 2'd2) ? 2'd0 : m3 + 2'd1);

    assign in_pay = (pos_ext >= head) && (pos_ext < (size - head));
    assign p      = pos_ext - head;

    // Header is 4 bytes, 4 mod 3 = 1
    assign p3 = cfg.strip_header ? ((m3 == 2'd0) ? 2'd2 : m3 - 2'd1) : m3;

    // p mod 6 from p mod 2 and p mod 3
    always_comb
    begin
        case ({p3, p[0]})
            3'b000:  ph6 = 3'd0;
            3'b001:  ph6 = 3'd3;
            3'b010:  ph6 = 3'd4;
            3'b011:  ph6 = 3'd1;
            3'b100:  ph6 = 3'd2;
            3'b101:  ph6 = 3'd5;
            default: ph6 = 3'd0;
        endcase
    end

    always_comb
    begin
        fmt_ok = 1'b1;
        gs     = 3'd1;
        ph     = 3'd0;
        case (cfg.pixel_format)
            FMT_YUV444, FMT_RGB888:
            begin
                gs = 3'd3;
                ph = {1'b0, p3};
            end
            FMT_YUV422:
            begin
                gs = 3'd4;
                ph = {1'b0, p[1:0]};
            end
            FMT_YUV411:
            begin
                gs = 3'd6;
                ph = ph6;
            end
            FMT_Y8:
            begin
                gs = 3'd1;
                ph = 3'd0;
            end
            FMT_Y16:
            begin
                gs = 3'd2;
                ph = {2'b00, p[0]};
            end
            default:
            begin
                fmt_ok = 1'b0;
            end
        endcase
    end

    // Byte belongs to a whole group when the group's end stays inside the payload
    assign grp_end  = {1'b0, p} + (SIZE_W + 1)'(gs) - (SIZE_W + 1)'(ph);
    assign full_grp = (grp_end <= {1'b0, payload});

    always_comb
    begin
        need = 1'b1;
        cmd  = CMD_EMIT_GRAY;
        case (cfg.pixel_format)
            FMT_YUV444:
                cmd = (ph == 3'd0) ? CMD_STORE_U :
                      (ph == 3'd1) ? CMD_STORE_A : CMD_EMIT_V;
            FMT_YUV422:
                cmd = (ph == 3'd0) ? CMD_STORE_U :
                      (ph == 3'd1) ? CMD_STORE_A :
                      (ph == 3'd2) ? CMD_EMIT_V  : CMD_EMIT_Y;
            FMT_YUV411:
                cmd = (ph == 3'd0) ? CMD_STORE_U :
                      (ph == 3'd1) ? CMD_STORE_A :
                      (ph == 3'd2) ? CMD_STORE_B :
                      (ph == 3'd3) ? CMD_EMIT_V2 : CMD_EMIT_Y;
            FMT_RGB888:
                cmd = (ph == 3'd0) ? CMD_STORE_U :
                      (ph == 3'd1) ? CMD_STORE_A : CMD_EMIT_RGB;
            FMT_Y8:
                cmd = CMD_EMIT_GRAY;
            FMT_Y16:
                need = (ph == 3'd0);   // low byte dropped
            default:
                need = 1'b0;
        endcase
    end

    assign push       = accept && fmt_ok && in_pay && full_grp && need;
    assign entry.cmd  = cmd;
    assign entry.data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            mod3_reg <= 2'd0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            mod3_reg <= mod3_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cppu_fifo.sv
// Short command queue between front and back.
`default_nettype none
module cppu_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cppu_pkg::entry_t wr_entry,
    output logic                  full,
    input  wire logic             pop,
    output cppu_pkg::entry_t      rd_entry,
    output logic                  empty
);
    import cppu_pkg::*;

    entry_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
        end
    end

endmodule
`default_nettype wire

>>> rtl/cppu_back.sv
// Back end: held group bytes and pixel request issue.
`default_nettype none
module cppu_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cppu_pkg::entry_t entry,
    input  wire logic             fifo_empty,
    output logic                  pop,
    input  wire logic             adv,
    output logic                  px_valid,
    output cppu_pkg::px_req_t     px
);
    import cppu_pkg::*;

    logic [7:0] u_reg, a_reg, b_reg, v_reg;
    logic [7:0] u_next, a_next, b_next, v_next;
    logic       second_reg, second_next;
    logic       px_valid_reg, px_valid_next;
    px_req_t    px_reg, px_next;

    assign pop      = adv && !second_reg && !fifo_empty;
    assign px_valid = px_valid_reg;
    assign px       = px_reg;

    always_comb
    begin
        u_next        = u_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        v_next        = v_reg;
        second_next   = second_reg;
        px_valid_next = px_valid_reg;
        px_next       = px_reg;
        if (adv)
        begin
            px_valid_next = 1'b0;
            if (second_reg)
            begin
                // second YUV411 pixel, uses the v just stored
                px_valid_next = 1'b1;
                px_next       = '{is_yuv: 1'b1, c0: b_reg, c1: u_reg, c2: v_reg, last: 1'b1};
                second_next   = 1'b0;
            end
            else if (!fifo_empty)
            begin
                case (entry.cmd)
                    CMD_STORE_U:
                        u_next = entry.data;
                    CMD_STORE_A:
                        a_next = entry.data;
                    CMD_STORE_B:
                        b_next = entry.data;
                    CMD_EMIT_V:
                    begin
                        v_next        = entry.data;
                        px_valid_next = 1'b1;
                        px_next       = '{is_yuv: 1'b1, c0: a_reg, c1: u_reg,
                                          c2: entry.data, last: 1'b1};
                    end
                    CMD_EMIT_V2:
                    begin
                        v_next        = entry.data;
                        second_next   = 1'b1;
                        px_valid_next = 1'b1;
                        px_next       = '{is_yuv: 1'b1, c0: a_reg, c1: u_reg,
                                          c2: entry.data, last: 1'b0};
                    end
                    CMD_EMIT_Y:
                    begin
                        px_valid_next = 1'b1;
                        px_next       = '{is_yuv: 1'b1, c0: entry.data, c1: u_reg,
                                          c2: v_reg, last: 1'b1};
                    end
                    CMD_EMIT_RGB:
                    begin
                        px_valid_next = 1'b1;
                        px_next       = '{is_yuv: 1'b0, c0: u_reg, c1: a_reg,
                                          c2: entry.data, last: 1'b1};
                    end
                    CMD_EMIT_GRAY:
                    begin
                        px_valid_next = 1'b1;
                        px_next       = '{is_yuv: 1'b0, c0: entry.data, c1: entry.data,
                                          c2: entry.data, last: 1'b1};
                    end
                    default:
                    begin
                        px_valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg        <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            v_reg        <= '0;
            second_reg   <= 1'b0;
            px_valid_reg <= 1'b0;
        end
        else
        begin
            u_reg        <= u_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            v_reg        <= v_next;
            second_reg   <= second_next;
            px_valid_reg <= px_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
    end

endmodule
`default_nettype wire

>>> rtl/cppu_cvt.sv
// Color pipeline: fixed-point ROM lookup, sum, shift and clamp.
`default_nettype none
module cppu_cvt #(
    parameter int FRACTION_BITS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               px_valid,
    input  wire cppu_pkg::px_req_t  px,
    output logic                    adv,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic                    run_last
);
    import cppu_pkg::*;

    localparam int TW = FRACTION_BITS + 11;   // table entry width
    localparam int SW = TW + 2;               // sum width
    localparam longint SCALE = longint'(1) << FRACTION_BITS;

    logic signed [TW-1:0] ty_rom  [256];
    logic signed [TW-1:0] tr_rom  [256];
    logic signed [TW-1:0] tg0_rom [256];
    logic signed [TW-1:0] tg1_rom [256];
    logic signed [TW-1:0] tb_rom  [256];

    // Tables built at elaboration, truncated toward zero
    for (genvar i = 0; i < 256; i++)
    begin : g_rom
        localparam longint D  = longint'(i) - 128;
        localparam longint YD = (i > 16) ? longint'(i) - 16 : 0;
        assign ty_rom[i]  = TW'((1164 * YD * SCALE) / 1000);
        assign tr_rom[i]  = TW'((1596 * D * SCALE) / 1000);
        assign tg0_rom[i] = TW'((-813 * D * SCALE) / 1000);
        assign tg1_rom[i] = TW'((-391 * D * SCALE) / 1000);
        assign tb_rom[i]  = TW'((2018 * D * SCALE) / 1000);
    end

    logic                 v1_reg, v2_reg, out_valid_reg;
    px_req_t              s1_reg, s2_reg;
    logic signed [TW-1:0] ty_reg, tr_reg, tg0_reg, tg1_reg, tb_reg;
    logic signed [SW-1:0] rs_reg, gs_reg, bs_reg;
    logic [7:0]           red_reg, green_reg, blue_reg;
    logic                 last_reg;
    logic [7:0]           r_cl, g_cl, b_cl;

    function automatic logic [7:0] clamp8(input logic signed [SW-1:0] s);
        logic [7:0] res;
        if (s[SW-1])
            res = 8'd0;
        else if (|s[SW-2:FRACTION_BITS+8])
            res = 8'hFF;
        else
            res = s[FRACTION_BITS+7:FRACTION_BITS];
        return res;
    endfunction

    assign adv = !out_valid_reg || out_ready;

    assign r_cl = s2_reg.is_yuv ? clamp8(rs_reg) : s2_reg.c0;
    assign g_cl = s2_reg.is_yuv ? clamp8(gs_reg) : s2_reg.c1;
    assign b_cl = s2_reg.is_yuv ? clamp8(bs_reg) : s2_reg.c2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= px_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= px;
            ty_reg    <= ty_rom[px.c0];
            tr_reg    <= tr_rom[px.c2];
            tg0_reg   <= tg0_rom[px.c2];
            tg1_reg   <= tg1_rom[px.c1];
            tb_reg    <= tb_rom[px.c1];
            s2_reg    <= s1_reg;
            rs_reg    <= SW'(ty_reg) + SW'(tr_reg);
            gs_reg    <= SW'(ty_reg) + SW'(tg0_reg) + SW'(tg1_reg);
            bs_reg    <= SW'(ty_reg) + SW'(tb_reg);
            red_reg   <= r_cl;
            green_reg <= g_cl;
            blue_reg  <= b_cl;
            last_reg  <= s2_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign run_last  = last_reg;

endmodule
`default_nettype wire

>>> rtl/camera_packet_pixel_unpacker.sv
// Top level: camera packet byte stream to RGB pixels.
// Byte path: queue entry, back pixel register, ROM lookup, sums, clamped output register.
// Throughput: one byte per clock while the 4-entry queue has room; each YUV411 v byte holds
//   the issue stage for its second pixel, so long YUV411 runs fill the queue and slow intake.
// Reset: config returns to YUV422, header strip on, 4096-byte packets; packet position
//   and held group bytes clear to zero; queue and pipeline empty. No clearing pass.
`default_nettype none
module camera_packet_pixel_unpacker #(
    parameter int PACKET_BYTES_MAX = 4096,
    parameter int FRACTION_BITS    = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input transaction
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       packet_start,
    // pixel output transaction
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic            run_last,
    // configuration write transaction
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [12:0] cfg_data
);
    import cppu_pkg::*;

    // Configuration registers. Writes are taken at any time; they are only
    // meaningful while no byte is in flight.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format <= FMT_YUV422;
            cfg_reg.strip_header <= 1'b1;
            cfg_reg.packet_bytes <= PB_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_data[2:0];
                CFG_STRIP_HEADER: cfg_reg.strip_header <= cfg_data[0];
                CFG_PACKET_BYTES: cfg_reg.packet_bytes <= cfg_data[PB_W-1:0];
                default:          cfg_reg <= cfg_reg;   // unmapped index ignored
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Front: tracks the byte position within the packet, strips header and
    // trailer, drops partial groups, and queues one command per useful byte.
    logic    fifo_push, fifo_pop, fifo_full, fifo_empty;
    entry_t  wr_entry, rd_entry;

    cppu_front #(
        .PACKET_BYTES_MAX (PACKET_BYTES_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .packet_start (packet_start),
        .cfg          (cfg_reg),
        .fifo_full    (fifo_full),
        .push         (fifo_push),
        .entry        (wr_entry)
    );

    // Queue decouples byte intake from pixel issue.
    cppu_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .wr_entry (wr_entry),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .rd_entry (rd_entry),
        .empty    (fifo_empty)
    );

    // Back: keeps chroma/luma bytes of the current group and issues pixels.
    logic    adv, px_valid;
    px_req_t px;

    cppu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry      (rd_entry),
        .fifo_empty (fifo_empty),
        .pop        (fifo_pop),
        .adv        (adv),
        .px_valid   (px_valid),
        .px         (px)
    );

    // Color pipeline: ROM lookup, sums, clamp into the output register.
    cppu_cvt #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cvt (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_valid  (px_valid),
        .px        (px),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .run_last  (run_last)
    );

    // Queue never written when full, never read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("command queue underflow");

    // A shown pixel only leaves after its transaction completes
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("pixel dropped before transaction");

endmodule
`default_nettype wire

>>> dv/tb_camera_packet_pixel_unpacker.sv
// Self-checking testbench for the camera packet pixel unpacker.
module tb_camera_packet_pixel_unpacker;
    import cppu_pkg::*;

    // Block parameters, also used by the pixel predictor below
    localparam int PACKET_MAX    = 4096;
    localparam int FRAC          = 10;
    // Pipeline depth from byte accept to pixel; used for settling before writes
    localparam int LATENCY       = 4;
    localparam int SETTLE_CYCLES = LATENCY + 6;
    localparam int MAX_IDLE      = 12;
    localparam int PHASE_COUNT   = 16;
    localparam int PHASE_BYTES   = 65;
    // Watchdog limit; this leaves plenty of margin over the slowest run
    localparam int CYCLE_LIMIT   = 600000;

    // Format codes the block does not decode; they must give no pixels
    localparam logic [2:0] FMT_UNUSED_LO = 3'd6;
    localparam logic [2:0] FMT_UNUSED_HI = 3'd7;

    // BT.601 coefficients in thousandths, and the chroma/luma offsets
    localparam longint COEF_Y  = 1164;
    localparam longint COEF_RV = 1596;
    localparam longint COEF_GV = -813;
    localparam longint COEF_GU = -391;
    localparam longint COEF_BU = 2018;
    localparam longint CHROMA_MID = 128;
    localparam int     LUMA_FLOOR = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        packet_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        run_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [12:0] cfg_data = 13'd0;

    camera_packet_pixel_unpacker #(
        .PACKET_BYTES_MAX(PACKET_MAX),
        .FRACTION_BITS   (FRAC)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .packet_start(packet_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .run_last    (run_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block: register values and unpacker state.
    // Mirrors reset values; updated on each accepted config transaction.
    // ------------------------------------------------------------------
    logic [2:0]  fmt_mirror   = FMT_YUV422;
    logic        strip_mirror = 1'b1;
    logic [12:0] bytes_mirror = 13'd4096;
    logic [11:0] pos_mirror   = '0;
    logic [2:0]  phase_mirror = '0;
    logic [7:0]  u_hold  = '0;
    logic [7:0]  ya_hold = '0;
    logic [7:0]  yb_hold = '0;
    logic [7:0]  v_hold  = '0;

    byte_item_t pending_bytes [$];   // bytes waiting for the driver
    pixel_t     pixel_expect  [$];   // predicted pixels, oldest first
    byte_item_t cur_byte;
    pixel_t     want_px;

    int  bytes_queued   = 0;
    int  bytes_accepted = 0;
    int  pixels_checked = 0;
    int  settings_used  = 0;
    int  errors         = 0;
    int  send_gap       = 0;
    int  take_gap       = 0;
    int  cycle_count    = 0;
    bit  idle_on        = 1'b1;

    logic [2:0] phase_fmt   [PHASE_COUNT];
    logic       phase_strip [PHASE_COUNT];
    int         phase_size  [PHASE_COUNT];

    // trunc(milli/1000 * d * 2^FRAC), rounding toward zero
    function automatic longint scaled_term(input longint milli, input longint d);
        return (milli * d * (longint'(1) <<< FRAC)) / 1000;
    endfunction

    function automatic logic [7:0] clamp8(input longint s);
        longint t;
        if (s < 0)
        begin
            return 8'd0;
        end
        t = s >>> FRAC;
        return (t > 255) ? 8'd255 : 8'(t);
    endfunction

    function automatic pixel_t yuv_pixel(input logic [7:0] y, input logic [7:0] u,
                                         input logic [7:0] v);
        longint luma, du, dv;
        pixel_t px;
        luma = scaled_term(COEF_Y, (y > LUMA_FLOOR) ? longint'(y) - LUMA_FLOOR : 64'sd0);
        du = longint'(u) - CHROMA_MID;
        dv = longint'(v) - CHROMA_MID;
        px.red   = clamp8(luma + scaled_term(COEF_RV, dv));
        px.green = clamp8(luma + scaled_term(COEF_GV, dv) + scaled_term(COEF_GU, du));
        px.blue  = clamp8(luma + scaled_term(COEF_BU, du));
        px.last  = 1'b0;
        return px;
    endfunction

    // Advance the shadow state by one byte and queue the pixels it yields.
    task automatic predict_byte(input logic [7:0] b, input logic start);
        int pos, pkt_size, head, payload, grp, fill, p, ph, n;
        pixel_t made [2];
        n = 0;
        pos = start ? 0 : int'(pos_mirror);
        pkt_size = int'(bytes_mirror);
        if (pkt_size < MIN_PACKET) pkt_size = MIN_PACKET;
        if (pkt_size > PACKET_MAX) pkt_size = PACKET_MAX;
        head = strip_mirror ? HEADER_BYTES : 0;
        payload = pkt_size - 2 * head;
        // Wrap at packet end; a stale position past a shrunk size also wraps
        pos_mirror = (pos + 1 >= pkt_size) ? 12'd0 : 12'(pos + 1);

        case (fmt_mirror)
            FMT_YUV444: grp = 3;
            FMT_YUV422: grp = 4;
            FMT_YUV411: grp = 6;
            FMT_RGB888: grp = 3;
            FMT_Y8:     grp = 1;
            FMT_Y16:    grp = 2;
            default:    grp = 0;   // unused code: held bytes stay put
        endcase
        if (grp == 0 || pos < head || pos >= head + payload)
        begin
            return;
        end
        p = pos - head;
        fill = payload - payload % grp;   // trailing partial group is skipped
        if (p >= fill)
        begin
            return;
        end
        ph = p % grp;
        phase_mirror = 3'(ph);

        case (fmt_mirror)
            FMT_YUV444:
            begin
                if (ph == 0) u_hold = b;
                else if (ph == 1) ya_hold = b;
                else
                begin
                    v_hold = b;
                    made[0] = yuv_pixel(ya_hold, u_hold, b);
                    n = 1;
                end
            end
            FMT_YUV422:
            begin
                if (ph == 0) u_hold = b;
                else if (ph == 1) ya_hold = b;
                else if (ph == 2)
                begin
                    v_hold = b;
                    made[0] = yuv_pixel(ya_hold, u_hold, b);
                    n = 1;
                end
                else
                begin
                    made[0] = yuv_pixel(b, u_hold, v_hold);
                    n = 1;
                end
            end
            FMT_YUV411:
            begin
                if (ph == 0) u_hold = b;
                else if (ph == 1) ya_hold = b;
                else if (ph == 2) yb_hold = b;
                else if (ph == 3)
                begin
                    // the v byte releases both held lumas
                    v_hold = b;
                    made[0] = yuv_pixel(ya_hold, u_hold, b);
                    made[1] = yuv_pixel(yb_hold, u_hold, b);
                    n = 2;
                end
                else
                begin
                    made[0] = yuv_pixel(b, u_hold, v_hold);
                    n = 1;
                end
            end
            FMT_RGB888:
            begin
                if (ph == 0) u_hold = b;
                else if (ph == 1) ya_hold = b;
                else
                begin
                    made[0] = '{u_hold, ya_hold, b, 1'b0};
                    n = 1;
                end
            end
            FMT_Y8:
            begin
                made[0] = '{b, b, b, 1'b0};
                n = 1;
            end
            default:
            begin
                // Y16: keep only the high byte
                if (ph == 0)
                begin
                    made[0] = '{b, b, b, 1'b0};
                    n = 1;
                end
            end
        endcase
        if (n > 0) made[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) pixel_expect.push_back(made[k]);
    endtask

    function automatic int idle_draw();
        return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: one transaction per pending item, random gap after each.
    // Prediction runs at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_byte(cur_byte.data, cur_byte.start);
                bytes_accepted++;
            end
            // Slot is free when nothing is offered or the offer just went through
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0 || pending_bytes.size() == 0)
                begin
                    if (send_gap > 0) send_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_byte = pending_bytes.pop_front();
                    in_valid     <= 1'b1;
                    data_byte    <= cur_byte.data;
                    packet_start <= cur_byte.start;
                    send_gap = idle_draw();
                end
            end
        end
    end

    function automatic void check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Pixel monitor: random back-pressure, in-order compare on every
    // accepted output transaction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixel_expect.size() == 0)
                begin
                    $error("pixel with none expected: red %0d green %0d blue %0d run_last %0d",
                           red, green, blue, run_last);
                    errors++;
                end
                else
                begin
                    want_px = pixel_expect.pop_front();
                    check_field("red", want_px.red, red);
                    check_field("green", want_px.green, green);
                    check_field("blue", want_px.blue, blue);
                    check_field("run_last", want_px.last, run_last);
                    pixels_checked++;
                end
                take_gap = idle_draw();
            end
            if (take_gap > 0)
            begin
                take_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("camera_packet_pixel_unpacker: mismatch");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic start);
        pending_bytes.push_back('{b, start});
        bytes_queued++;
    endtask

    // Config write; only called with the byte path drained.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PIXEL_FORMAT: fmt_mirror   = value[2:0];
            CFG_STRIP_HEADER: strip_mirror = value[0];
            CFG_PACKET_BYTES: bytes_mirror = value;
            default: ;
        endcase
    endtask

    // Wait for every byte accepted and every pixel seen, then let the pipe settle
    // (bytes that make no pixel may still be in flight).
    task automatic wait_drained();
        do @(posedge clk);
        while (bytes_accepted != bytes_queued || pixel_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly whole packets (12 to 64 bytes when larger) with random content; some cut short, some without
    // a start marker (run on the wrap), and rare stray start markers.
    task automatic queue_packets(input int count, input int eff_size, input bit open_mid);
        int sent, len;
        bit start;
        sent = 0;
        while (sent < count)
        begin
            len = (eff_size > 64) ? $urandom_range(12, 64) : eff_size;
            if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
            start = ($urandom_range(0, 5) != 0);
            if (sent == 0 && open_mid) start = 1'b0;
            for (int k = 0; k < len && sent < count; k++)
            begin
                queue_byte(random_byte(), (k == 0) ? start : ($urandom_range(0, 63) == 0));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int pkt_size, eff;
        bit open_mid;

        // Phase plan: every format incl. the two unused codes, both strip
        // modes, and sizes at and beyond both ends of the legal range.
        phase_fmt = '{FMT_YUV444, FMT_YUV422, FMT_YUV411, FMT_RGB888,
                      FMT_Y8, FMT_Y16, FMT_YUV411, FMT_UNUSED_HI,
                      FMT_YUV444, FMT_YUV422, FMT_RGB888, FMT_Y16,
                      FMT_UNUSED_LO, FMT_YUV411, FMT_Y8, FMT_YUV422};
        phase_strip = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
        // -1 picks a random small size
        phase_size = '{15, 12, 4096, 21, 0, 13, 8191, 16,
                       -1, -1, -1, -1, 5, -1, -1, 4095};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: YUV422, header strip on, 4096-byte packets.
        // Header bytes give nothing, then one full u,Y0,v,Y1 group.
        queue_byte(8'd10, 1'b1);
        queue_byte(8'd20, 1'b0);
        queue_byte(8'd30, 1'b0);
        queue_byte(8'd40, 1'b0);
        queue_byte(8'd0, 1'b0);
        queue_byte(8'd255, 1'b0);
        queue_byte(8'd255, 1'b0);
        queue_byte(8'd0, 1'b0);
        settings_used++;
        wait_drained();

        // YUV411, no strip, size below the minimum (runs as 12 bytes):
        // two full groups with extreme values, then the wrap into the next
        // packet without a start marker.
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_YUV411));
        write_reg(CFG_STRIP_HEADER, 13'd0);
        write_reg(CFG_PACKET_BYTES, 13'd5);
        settings_used++;
        queue_byte(8'd0, 1'b1);
        queue_byte(8'd255, 1'b0);
        queue_byte(8'd16, 1'b0);
        queue_byte(8'd255, 1'b0);
        queue_byte(8'd0, 1'b0);
        queue_byte(8'd17, 1'b0);
        queue_byte(8'd255, 1'b0);
        queue_byte(8'd128, 1'b0);
        queue_byte(8'd235, 1'b0);
        queue_byte(8'd0, 1'b0);
        queue_byte(8'd255, 1'b0);
        queue_byte(8'd15, 1'b0);
        queue_byte(8'd128, 1'b0);
        queue_byte(8'd128, 1'b0);
        queue_byte(8'd128, 1'b0);
        queue_byte(8'd128, 1'b0);
        queue_byte(8'd200, 1'b0);
        queue_byte(8'd100, 1'b0);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_drained();
            pkt_size = (phase_size[ph] < 0) ? $urandom_range(12, 48) : phase_size[ph];
            eff = (pkt_size < MIN_PACKET) ? MIN_PACKET :
                  (pkt_size > PACKET_MAX) ? PACKET_MAX : pkt_size;
            // every fourth phase runs with no idling on either side
            idle_on = (ph % 4 != 3);
            write_reg(CFG_PIXEL_FORMAT, 13'(phase_fmt[ph]));
            write_reg(CFG_STRIP_HEADER, 13'(phase_strip[ph]));
            write_reg(CFG_PACKET_BYTES, 13'(pkt_size));
            settings_used++;
            // Sometimes continue from the old position, which may lie past
            // the new packet size.
            open_mid = $urandom_range(0, 1);
            if (ph % 2 == 1)
            begin
                // sender stops mid-phase until every pixel is out
                queue_packets(PHASE_BYTES / 2, eff, open_mid);
                do @(posedge clk);
                while (bytes_accepted != bytes_queued || pixel_expect.size() != 0);
                queue_packets(PHASE_BYTES - PHASE_BYTES / 2, eff, 1'b0);
            end
            else
            begin
                queue_packets(PHASE_BYTES, eff, open_mid);
            end
        end

        wait_drained();
        if (pixel_expect.size() != 0)
        begin
            $error("%0d expected pixels never arrived", pixel_expect.size());
            errors++;
        end
        $display("Covered %0d bytes and %0d pixels over %0d register settings,",
                 bytes_accepted, pixels_checked, settings_used);
        $display("all six formats, unused format codes, both strip modes, out-of-range sizes.");
        if (errors == 0)
        begin
            $display("camera_packet_pixel_unpacker: match");
        end
        else
        begin
            $display("camera_packet_pixel_unpacker: mismatch");
        end
        $finish;
    end

endmodule
